// ===== src/bca_pkg.sv =====
// ----------------------------------------------------------------------------
// bca_pkg
// Shared sizes, codes and types of the bitmap cluster allocator.
// ----------------------------------------------------------------------------
package bca_pkg;

	// field widths
	localparam int ADDR_W    = 48;
	localparam int COUNT_W   = 32;
	localparam int CB_W      = 17;
	localparam int MBU_W     = 8;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 2;

	// map geometry
	localparam int NUM_CLUSTERS = 1024;
	localparam int ROW_W        = (NUM_CLUSTERS >= 32) ? 32 : 8;
	localparam int BIT_W        = $clog2(ROW_W);
	localparam int ROWS         = (NUM_CLUSTERS + ROW_W - 1) / ROW_W;
	localparam int RA_W         = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CIDX_W       = RA_W + BIT_W;
	localparam int CW           = CIDX_W + 1;
	localparam int PROD_W       = CW + CB_W;

	// divider
	localparam int DIV_STEPS = ADDR_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_BYTES     = 2'd2;

	localparam logic [CB_W-1:0]  CLUSTER_BYTES_RST = 17'd4096;
	localparam logic [MBU_W-1:0] MAP_BYTES_RST     = 8'd128;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_NO_RUN  = 2'd1,
		STAT_IGNORED = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV_FIRST,
		S_DIV_NEED,
		S_SCAN_RD,
		S_SCAN_BIT,
		S_MARK_RD,
		S_MARK_WR,
		S_DONE
	} fsm_state_t;

	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] dividend;
		logic [CB_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             rd_en;
		logic [RA_W-1:0]  rd_addr;
		logic             wr_en;
		logic [RA_W-1:0]  wr_addr;
		logic [ROW_W-1:0] wr_data;
	} ram_ctrl_t;

endpackage

// ===== src/bca_if.sv =====
// ----------------------------------------------------------------------------
// bca_if
// Request and response channels of the bitmap cluster allocator.
// ----------------------------------------------------------------------------
interface bca_req_if import bca_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic [COUNT_W-1:0] byte_count;
	logic [ADDR_W-1:0]  free_address;

	modport source (output valid, output operation, output byte_count,
		output free_address, input ready);
	modport sink (input valid, input operation, input byte_count,
		input free_address, output ready);
endinterface

interface bca_rsp_if import bca_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   block_address;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output block_address, output status, input ready);
	modport sink (input valid, input block_address, input status, output ready);
endinterface

// ===== src/bca_div.sv =====
// ----------------------------------------------------------------------------
// bca_div
// Restoring divider, one quotient bit per cycle, shared by all requests.
// ----------------------------------------------------------------------------
module bca_div import bca_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ADDR_W-1:0]    dvd_q;
	logic [CB_W:0]        rem_q;
	logic [CB_W-1:0]      dsr_q;

	logic [CB_W:0] rem_sh;
	logic          ge;

	always_comb begin
		rem_sh = {rem_q[CB_W-1:0], dvd_q[ADDR_W-1]};
		ge     = rem_sh >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
			dvd_q <= {dvd_q[ADDR_W-2:0], ge};
		end else if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ===== src/bca_map_ram.sv =====
// ----------------------------------------------------------------------------
// bca_map_ram
// Cluster used map, one row of cluster bits per entry, registered read.
// ----------------------------------------------------------------------------
module bca_map_ram import bca_pkg::*; (
	input  logic             clk,
	input  ram_ctrl_t        ctrl,
	output logic [ROW_W-1:0] rd_data
);

	logic [ROW_W-1:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= ctrl.wr_data;
		end
	end

	// read data holds between reads
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_data <= mem[ctrl.rd_addr];
		end
	end

endmodule

// ===== src/bitmap_cluster_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_cluster_allocator_unit
// First-fit cluster allocator over a bitmap held in a row-wide memory.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready): an allocate carries a byte count, a
// free carries a byte count and a start address. Each request gives exactly
// one transfer on rsp with an address and a status code. The three
// configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user is to write them only while the block is idle; the block does not enforce it.
// One request is in work at a time. A size is turned into clusters by a
// shared one-bit-per-cycle divider of 48 steps; a free runs it up to twice. An
// allocate then reads the map a 32-cluster row at a time and scans it one
// cluster per cycle; on a hit each row of the run is read and written back. A
// free reads and writes back each row that it clears; a free ignored on its
// inputs skips the divider and goes straight to its result.
// After reset the map memory is cleared row by row, all 32 rows, with req
// ready held low; configuration writes are taken during that sweep.
// A result waits in the output register while rsp is stalled; the next
// request is still accepted and worked on up to its own result.
module bitmap_cluster_allocator_unit import bca_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bca_req_if.sink              req,
	bca_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	fsm_state_t state_q, state_d;

	logic [ADDR_W-1:0]   region_base_q;
	logic [CB_W-1:0]     cluster_bytes_q;
	logic [MBU_W-1:0]    map_bytes_q;

	logic                op_q;
	logic [COUNT_W-1:0]  count_q;
	logic [CB_W-1:0]     g_q;
	logic [CW-1:0]       limit_q;
	logic [CW-1:0]       need_q;
	logic [CW-1:0]       run_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [RA_W-1:0]     row_q;
	logic [RA_W-1:0]     last_row_q;
	logic [BIT_W-1:0]    bit_q;
	logic                mark_set_q;
	logic [PROD_W-1:0]   prod_q;
	status_t             res_status_q;

	logic                rsp_valid_q;
	logic [ADDR_W-1:0]   rsp_addr_q;
	status_t             rsp_status_q;

	div_req_t            div_req;
	div_rsp_t            div_rsp;
	ram_ctrl_t           ram_ctrl;
	logic [ROW_W-1:0]    ram_rd;

	logic [CB_W-1:0]     gran;
	logic [CW-1:0]       limit_c;
	logic [MBU_W+2:0]    lim_raw;
	logic                free_bad;
	logic                accept;
	logic [CW-1:0]       idx;
	logic [CW-1:0]       run_inc;
	logic                cur_used;
	logic                hit;
	logic                scan_last;
	logic [CW-1:0]       lo_new;
	logic                last_bit;
	logic [ADDR_W-1:0]   free_sum;
	logic [CW-1:0]       free_hi;
	logic [CW-1:0]       free_hm1;
	logic                first_out;
	logic                need_bad;
	logic [ROW_W-1:0]    mark_mask;
	logic [CW-1:0]       mark_idx;
	logic                rsp_load;

	bca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bca_map_ram u_ram (
		.clk     (clk),
		.ctrl    (ram_ctrl),
		.rd_data (ram_rd)
	);

	// request decode and scan datapath
	always_comb begin
		gran     = (cluster_bytes_q == '0) ? CB_W'(1) : cluster_bytes_q;
		lim_raw  = {map_bytes_q, 3'b000};
		if (32'(lim_raw) > 32'(NUM_CLUSTERS)) begin
			limit_c = CW'(NUM_CLUSTERS);
		end else begin
			limit_c = CW'(lim_raw);
		end
		free_bad = (req.free_address == '0) || (req.byte_count == '0) ||
			(req.free_address < region_base_q);
		accept   = req.valid && req.ready;

		idx       = {1'b0, row_q, bit_q};
		cur_used  = ram_rd[bit_q];
		run_inc   = run_q + CW'(1);
		hit       = !cur_used && (run_inc == need_q);
		// last active cluster, the scan ends here on a miss
		scan_last = (idx + CW'(1)) >= limit_q;
		lo_new    = idx + CW'(1) - need_q;
		last_bit  = bit_q == {BIT_W{1'b1}};

		free_sum = ADDR_W'(lo_q) + div_rsp.quotient;
		free_hi  = (free_sum > ADDR_W'(limit_q)) ? limit_q : free_sum[CW-1:0];
		free_hm1 = free_hi - CW'(1);

		first_out = div_rsp.quotient >= ADDR_W'(limit_q);
		need_bad  = (div_rsp.quotient == '0) || (div_rsp.quotient > ADDR_W'(limit_q));

		for (int k = 0; k < ROW_W; k++) begin
			mark_idx     = {1'b0, row_q, BIT_W'(k)};
			mark_mask[k] = (mark_idx >= lo_q) && (mark_idx < hi_q);
		end
	end

	// next state and strobes
	always_comb begin
		state_d          = state_q;
		req.ready        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = ADDR_W'(count_q) + ADDR_W'(g_q) - ADDR_W'(1);
		div_req.divisor  = g_q;
		ram_ctrl.rd_en   = 1'b0;
		ram_ctrl.rd_addr = row_q;
		ram_ctrl.wr_en   = 1'b0;
		ram_ctrl.wr_addr = row_q;
		ram_ctrl.wr_data = mark_set_q ? (ram_rd | mark_mask) : (ram_rd & ~mark_mask);
		rsp_load         = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ram_ctrl.wr_en   = 1'b1;
				ram_ctrl.wr_data = '0;
				if (row_q == RA_W'(ROWS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready       = 1'b1;
				div_req.divisor = gran;
				if (req.valid) begin
					if (req.operation == OP_ALLOC) begin
						div_req.start    = 1'b1;
						div_req.dividend = ADDR_W'(req.byte_count) + ADDR_W'(gran) -
							ADDR_W'(1);
						state_d          = S_DIV_NEED;
					end else if (free_bad) begin
						state_d = S_DONE;
					end else begin
						div_req.start    = 1'b1;
						div_req.dividend = req.free_address - region_base_q;
						state_d          = S_DIV_FIRST;
					end
				end
			end
			S_DIV_FIRST: begin
				if (div_rsp.done) begin
					if (first_out) begin
						state_d = S_DONE;
					end else begin
						div_req.start = 1'b1;
						state_d       = S_DIV_NEED;
					end
				end
			end
			S_DIV_NEED: begin
				if (div_rsp.done) begin
					if (op_q == OP_FREE) begin
						state_d = S_MARK_RD;
					end else if (need_bad) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN_RD;
					end
				end
			end
			S_SCAN_RD: begin
				ram_ctrl.rd_en = 1'b1;
				state_d        = S_SCAN_BIT;
			end
			S_SCAN_BIT: begin
				if (hit) begin
					state_d = S_MARK_RD;
				end else if (scan_last) begin
					state_d = S_DONE;
				end else if (last_bit) begin
					state_d = S_SCAN_RD;
				end
			end
			S_MARK_RD: begin
				ram_ctrl.rd_en = 1'b1;
				state_d        = S_MARK_WR;
			end
			S_MARK_WR: begin
				// the row is written back before the next one is read
				ram_ctrl.wr_en = 1'b1;
				if (row_q == last_row_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_MARK_RD;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q   <= '0;
			cluster_bytes_q <= CLUSTER_BYTES_RST;
			map_bytes_q     <= MAP_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REGION_BASE:   region_base_q   <= cfg_data[ADDR_W-1:0];
				CFG_CLUSTER_BYTES: cluster_bytes_q <= cfg_data[CB_W-1:0];
				CFG_MAP_BYTES:     map_bytes_q     <= cfg_data[MBU_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					row_q <= row_q + RA_W'(1);
				end
				S_DIV_NEED: begin
					if (div_rsp.done) begin
						if (op_q == OP_FREE) begin
							row_q <= lo_q[CIDX_W-1:BIT_W];
						end else begin
							row_q <= '0;
						end
					end
				end
				S_SCAN_BIT: begin
					if (hit) begin
						row_q <= lo_new[CIDX_W-1:BIT_W];
					end else if (last_bit) begin
						row_q <= row_q + RA_W'(1);
					end
				end
				S_MARK_WR: begin
					row_q <= row_q + RA_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q         <= req.operation;
					count_q      <= req.byte_count;
					g_q          <= gran;
					limit_q      <= limit_c;
					res_status_q <= (req.operation == OP_FREE && free_bad) ?
						STAT_IGNORED : STAT_DONE;
				end
			end
			S_DIV_FIRST: begin
				if (div_rsp.done) begin
					if (first_out) begin
						res_status_q <= STAT_IGNORED;
					end else begin
						lo_q <= div_rsp.quotient[CW-1:0];
					end
				end
			end
			S_DIV_NEED: begin
				if (div_rsp.done) begin
					if (op_q == OP_FREE) begin
						hi_q       <= free_hi;
						last_row_q <= free_hm1[CIDX_W-1:BIT_W];
						mark_set_q <= 1'b0;
					end else if (need_bad) begin
						res_status_q <= STAT_NO_RUN;
					end else begin
						need_q <= div_rsp.quotient[CW-1:0];
						run_q  <= '0;
						bit_q  <= '0;
					end
				end
			end
			S_SCAN_BIT: begin
				if (hit) begin
					lo_q       <= lo_new;
					hi_q       <= idx + CW'(1);
					last_row_q <= row_q;
					mark_set_q <= 1'b1;
				end else if (scan_last) begin
					res_status_q <= STAT_NO_RUN;
				end else begin
					run_q <= cur_used ? '0 : run_inc;
					bit_q <= bit_q + BIT_W'(1);
				end
			end
			S_MARK_RD: begin
				prod_q <= PROD_W'(lo_q) * PROD_W'(g_q);
			end
			S_DONE: begin
				if (rsp_load) begin
					rsp_status_q <= res_status_q;
					if (op_q == OP_ALLOC && res_status_q == STAT_DONE) begin
						rsp_addr_q <= region_base_q + ADDR_W'(prod_q);
					end else begin
						rsp_addr_q <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.block_address = rsp_addr_q;
	assign rsp.status        = rsp_status_q;

endmodule

// ===== src/bca_chk.sv =====
// ----------------------------------------------------------------------------
// bca_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bca_chk import bca_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [ADDR_W-1:0]   rsp_block_address,
	input logic [STATUS_W-1:0] rsp_status
);

	logic [1:0] pend_q;

	// requests taken and not yet answered, one in work plus one waiting result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({req_valid && req_ready, rsp_valid && rsp_ready})
				2'b10: pend_q <= pend_q + 2'd1;
				2'b01: pend_q <= pend_q - 2'd1;
				default: begin
				end
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_block_address) && $stable(rsp_status))
		else $error("result changed while stalled");

	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_DONE |-> rsp_block_address == '0)
		else $error("failed request carries an address");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |-> pend_q != 2'd0)
		else $error("result without a request");

endmodule

bind bitmap_cluster_allocator_unit bca_chk u_bca_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_block_address (rsp.block_address),
	.rsp_status        (rsp.status)
);

// ===== sim/bitmap_cluster_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_cluster_allocator_unit_tb
// Drives allocate and free requests into the cluster allocator. The requests
// are first a directed set, then random batches under several map layouts and
// idle patterns. Every reply is checked against a bitmap predictor kept here.
// ----------------------------------------------------------------------------
module bitmap_cluster_allocator_unit_tb;
	import bca_pkg::*;

	localparam int CLUSTERS_PER_BYTE = 8;
	localparam int CYCLE_LIMIT       = 3000000;
	localparam int LONG_HOLD         = 3000;

	typedef struct {
		logic               operation;
		logic [COUNT_W-1:0] byte_count;
		logic [ADDR_W-1:0]  free_address;
	} request_t;

	typedef struct {
		logic [ADDR_W-1:0] block_address;
		status_t           status;
	} reply_t;

	typedef struct {
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] bytes;
	} held_block_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	bca_req_if req_ch();
	bca_rsp_if rsp_ch();

	bitmap_cluster_allocator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	bit                cluster_map [NUM_CLUSTERS];
	logic [ADDR_W-1:0] cur_base          = '0;
	logic [CB_W-1:0]   cur_cluster_bytes = CLUSTER_BYTES_RST;
	logic [MBU_W-1:0]  cur_map_bytes     = MAP_BYTES_RST;

	request_t    request_queue[$];
	reply_t      expected_replies[$];
	held_block_t held_blocks[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_start     = 0;
	int hold_left      = 0;
	int mismatches     = 0;
	int cycle_count    = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned bytes_per_cluster();
		return (cur_cluster_bytes == '0) ? 64'd1 : 64'(cur_cluster_bytes);
	endfunction

	function automatic longint unsigned clusters_in_use();
		longint unsigned n;
		n = 64'(cur_map_bytes) * CLUSTERS_PER_BYTE;
		return (n > NUM_CLUSTERS) ? 64'(NUM_CLUSTERS) : n;
	endfunction

	function automatic longint unsigned clusters_spanned(longint unsigned bytes);
		longint unsigned g;
		g = bytes_per_cluster();
		return (bytes + g - 1) / g;
	endfunction

	// first-fit allocate, or free, over the active part of the map, updates the map in place
	function automatic reply_t serve_request(request_t rq);
		reply_t rp;
		longint unsigned gran, lim, need, run, first, stop, k;
		bit found;
		gran = bytes_per_cluster();
		lim = clusters_in_use();
		rp.block_address = '0;
		rp.status = STAT_DONE;
		found = 1'b0;
		first = 0;
		run = 0;
		if (rq.operation == OP_ALLOC) begin
			need = clusters_spanned(64'(rq.byte_count));
			if (need != 0 && need <= lim) begin
				for (k = 0; k < lim && !found; k++) begin
					if (cluster_map[k]) begin
						run = 0;
					end else begin
						run++;
						if (run == need) begin
							first = k + 1 - need;
							found = 1'b1;
						end
					end
				end
			end
			if (found) begin
				for (k = first; k < first + need; k++)
					cluster_map[k] = 1'b1;
				rp.block_address = ADDR_W'(64'(cur_base) + first * gran);
			end else begin
				rp.status = STAT_NO_RUN;
			end
		end else begin
			if (rq.free_address == '0 || rq.byte_count == '0 || rq.free_address < cur_base) begin
				rp.status = STAT_IGNORED;
			end else begin
				first = 64'(rq.free_address - cur_base) / gran;
				if (first >= lim) begin
					rp.status = STAT_IGNORED;
				end else begin
					// a run past the end is clipped to the active map
					stop = first + clusters_spanned(64'(rq.byte_count));
					if (stop > lim)
						stop = lim;
					for (k = first; k < stop; k++)
						cluster_map[k] = 1'b0;
				end
			end
		end
		return rp;
	endfunction

	function automatic logic [ADDR_W-1:0] rand48();
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	function automatic void queue_alloc(longint unsigned bytes);
		request_queue.push_back('{OP_ALLOC, COUNT_W'(bytes), rand48()});
	endfunction

	function automatic void queue_free(logic [ADDR_W-1:0] addr, longint unsigned bytes);
		request_queue.push_back('{OP_FREE, COUNT_W'(bytes), addr});
	endfunction

	function automatic void note_failure(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_REGION_BASE:   cur_base = val[ADDR_W-1:0];
			CFG_CLUSTER_BYTES: cur_cluster_bytes = val[CB_W-1:0];
			CFG_MAP_BYTES:     cur_map_bytes = val[MBU_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_layout(logic [ADDR_W-1:0] base, longint unsigned cb,
		longint unsigned mbu);
		write_reg(CFG_REGION_BASE, CFG_W'(base));
		write_reg(CFG_CLUSTER_BYTES, CFG_W'(cb));
		write_reg(CFG_MAP_BYTES, CFG_W'(mbu));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (request_queue.size() != 0 || expected_replies.size() != 0 || req_ch.valid);
	endtask

	// request driver: the head of request_queue is the item on the bus
	always @(posedge clk) begin : drive_requests
		request_t taken;
		reply_t outcome;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				taken = request_queue.pop_front();
				outcome = serve_request(taken);
				expected_replies.push_back(outcome);
				if (taken.operation == OP_ALLOC && outcome.status == STAT_DONE)
					held_blocks.push_back('{outcome.block_address, taken.byte_count});
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_ch.valid <= 1'b1;
					req_ch.operation <= request_queue[0].operation;
					req_ch.byte_count <= request_queue[0].byte_count;
					req_ch.free_address <= request_queue[0].free_address;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (hold_start != 0) begin
				hold_left = hold_start;
				hold_start = 0;
			end
			rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
			if (hold_left != 0)
				hold_left--;
		end
	end

	always @(posedge clk) begin : check_reply
		reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_replies.size() == 0) begin
				note_failure($sformatf("unexpected transfer: addr %012h status %0d",
					rsp_ch.block_address, rsp_ch.status));
			end else begin
				want = expected_replies.pop_front();
				if (rsp_ch.block_address !== want.block_address || rsp_ch.status !== want.status)
					note_failure($sformatf(
						"reply mismatch: expected addr %012h status %0d, got addr %012h status %0d",
						want.block_address, want.status, rsp_ch.block_address, rsp_ch.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int ph, r, n, idx, gran, lim, made;
		longint unsigned cb, mbu;
		logic [ADDR_W-1:0] base;
		held_block_t blk;

		req_ch.valid = 1'b0;
		req_ch.operation = OP_ALLOC;
		req_ch.byte_count = '0;
		req_ch.free_address = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_REGION_BASE;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset layout: base 0, 4 KiB clusters, full map
		queue_alloc(1);
		queue_alloc(0);
		queue_alloc(4096);
		queue_alloc(4097);
		queue_alloc(32'hFFFF_FFFF);
		queue_free('0, 4096);
		queue_free(48'd4096, 0);
		queue_free(48'd4196, 1);
		queue_free(48'd4096, 4096);
		queue_free('1, 1);
		queue_alloc(1);
		queue_alloc(1020 * 4096);
		queue_alloc(1);
		queue_free(48'd8192, 32'hFFFF_FFFF);
		wait_idle();

		// one map byte at the top of the address space, results wrap
		set_layout(48'hFFFF_FFFF_0000, 65536, 1);
		queue_free(48'h1000, 1);
		queue_alloc(2 * 65536);
		queue_alloc(8 * 65536);
		queue_free(48'hFFFF_FFFF_0064, 20 * 65536);
		queue_alloc(8 * 65536);
		queue_free(48'hFFFF_FFFF_0000, 1);
		wait_idle();

		// zero cluster size acts as one byte
		set_layout('0, 0, 2);
		queue_alloc(3);
		queue_free(48'd9, 1);
		queue_free(48'd16, 5);
		queue_alloc(1);

		for (ph = 0; ph < 8; ph++) begin
			wait_idle();
			case ($urandom_range(0, 2))
				0: base = '0;
				1: base = ADDR_W'(48'hFFFF_FFFF_FFFF - $urandom_range(0, 1 << 20));
				default: base = rand48();
			endcase
			case ($urandom_range(0, 3))
				0: cb = 1;
				1: cb = 65536;
				2: cb = 1 << $urandom_range(0, 16);
				default: cb = $urandom_range(1, 65536);
			endcase
			mbu = (ph == 3) ? 128 : (ph == 6) ? 64 : $urandom_range(1, 16);
			set_layout(base, cb, mbu);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 69;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 69;
				end
				default: begin
					send_idle_pct = 37;
					recv_stall_pct = 37;
				end
			endcase
			// receiver blocks while the sender keeps pushing
			if (ph == 4)
				hold_start = LONG_HOLD;
			held_blocks.delete();
			gran = int'(bytes_per_cluster());
			lim = int'(clusters_in_use());
			// clear the active map, all but cluster 0 when the base is zero
			queue_free((base == '0) ? ADDR_W'(gran) : base, 32'hFFFF_FFFF);

			for (made = 0; made < 64; made++) begin
				if (made % 6 == 0)
					while (request_queue.size() != 0)
						@(negedge clk);
				r = $urandom_range(0, 99);
				if (r >= 45 && r < 80 && held_blocks.size() == 0)
					r = 0;
				if (r < 45) begin
					n = $urandom_range(1, (lim > 3) ? lim / 3 : 1);
					queue_alloc(longint'(n) * gran - $urandom_range(0, gran - 1));
				end else if (r < 80) begin
					idx = $urandom_range(0, held_blocks.size() - 1);
					blk = held_blocks[idx];
					// now and then leave it listed so it gets freed twice
					if ($urandom_range(0, 9) != 0)
						held_blocks.delete(idx);
					queue_free(blk.addr + (($urandom_range(0, 1) != 0) ?
						$urandom_range(0, gran - 1) : 0),
						($urandom_range(0, 3) != 0) ? blk.bytes : $urandom_range(1, blk.bytes));
				end else if (r < 86) begin
					queue_alloc($urandom());
				end else if (r < 88) begin
					queue_alloc(0);
				end else if (r < 94) begin
					queue_free(rand48(), $urandom());
				end else if (r < 96) begin
					queue_free('0, $urandom());
				end else if (r < 98) begin
					queue_free(base + ADDR_W'(gran), 0);
				end else begin
					queue_free((base != '0) ? rand48() % base : rand48(),
						$urandom_range(1, 1 << 20));
				end
			end
		end

		wait_idle();
		repeat (40) @(negedge clk);
		if (mismatches == 0 && expected_replies.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/bca_pkg.sv
src/bca_if.sv
src/bca_div.sv
src/bca_map_ram.sv
src/bitmap_cluster_allocator_unit.sv
src/bca_chk.sv
sim/bitmap_cluster_allocator_unit_tb.sv
